// ===== hdl/cursor_sequence_store_core_macros.svh =====
// Assertion macros for the cursor sequence store.
// Included by the top level; needs no other file.
`ifndef CURSOR_SEQUENCE_STORE_CORE_MACROS_SVH
`define CURSOR_SEQUENCE_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor store assertion failed");

// Next-cycle implication, disabled during reset
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor store assertion failed");

`endif

// ===== hdl/csc_pkg.sv =====
// Shared codes and types for the cursor sequence store.
// No dependencies.
`default_nettype none

package csc_pkg;

    localparam int unsigned CAPACITY_DEF    = 32;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Command codes
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_ADVANCE = 3'd1;
    localparam logic [2:0] CMD_INSERT  = 3'd2;
    localparam logic [2:0] CMD_ATTACH  = 3'd3;
    localparam logic [2:0] CMD_REMOVE  = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic open_gap;   // cells above pos shift up, cell at pos loads
        logic close_gap;  // cells at or above pos take their right neighbor
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/csc_cell.sv =====
// One storage cell of the cursor sequence store chain.
// Depends on csc_pkg for the cell control struct.
`default_nettype none

module csc_cell #(
    parameter int unsigned INDEX       = 0,
    parameter int unsigned POS_W       = 6,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire csc_pkg::t_cell_ctl     i_ctl,
    input  wire logic [POS_W-1:0]       i_pos,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_left,
    input  wire logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0]      o_q
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_q;
    logic [VALUE_WIDTH-1:0] n_q;

    // Local shift / load / hold decision
    always_comb begin
        n_q = r_q;
        if (i_ctl.open_gap) begin
            if (MY_POS == i_pos) begin
                n_q = i_value;
            end else if (MY_POS > i_pos) begin
                n_q = i_left;
            end
        end else if (i_ctl.close_gap) begin
            if (MY_POS >= i_pos) begin
                n_q = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== hdl/csc_ctrl.sv =====
// Count and cursor controller of the cursor sequence store.
// Depends on csc_pkg for command/error codes and the cell control struct.
`default_nettype none

module csc_ctrl #(
    parameter int unsigned CAPACITY = csc_pkg::CAPACITY_DEF,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic [2:0]         i_command,
    output csc_pkg::t_cell_ctl      o_ctl,
    output logic [CNT_W-1:0]        o_pos,
    output logic [CNT_W-1:0]        o_count,
    output logic [CNT_W-1:0]        o_cursor,
    output logic [1:0]              o_error
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_cursor;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   n_cursor;
    logic [CNT_W-1:0]   w_pos;
    logic [1:0]         w_error;
    csc_pkg::t_cell_ctl w_ctl;
    logic               w_full;
    logic               w_has;

    assign w_full = (r_count == CAP_C);
    assign w_has  = (r_cursor < r_count);

    // Command decode
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        w_pos    = r_cursor;
        w_error  = csc_pkg::ERR_OK;
        w_ctl    = '0;
        case (i_command)
            csc_pkg::CMD_START: begin
                n_cursor = '0;
            end
            csc_pkg::CMD_ADVANCE: begin
                if (w_has) begin
                    n_cursor = r_cursor + CNT_W'(1);
                end
            end
            csc_pkg::CMD_INSERT: begin
                if (w_full) begin
                    w_error = csc_pkg::ERR_FULL;
                end else begin
                    w_pos          = w_has ? r_cursor : '0;
                    w_ctl.open_gap = 1'b1;
                    n_cursor       = w_pos;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            csc_pkg::CMD_ATTACH: begin
                if (w_full) begin
                    w_error = csc_pkg::ERR_FULL;
                end else begin
                    // after the current item, or at the back
                    w_pos          = w_has ? (r_cursor + CNT_W'(1)) : r_count;
                    w_ctl.open_gap = 1'b1;
                    n_cursor       = w_pos;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            csc_pkg::CMD_REMOVE: begin
                if (!w_has) begin
                    w_error = csc_pkg::ERR_EMPTY;
                end else begin
                    w_ctl.close_gap = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            default: begin
                // unused codes: no operation
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (i_fire) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    assign o_ctl    = i_fire ? w_ctl : '0;
    assign o_pos    = w_pos;
    assign o_count  = r_count;
    assign o_cursor = r_cursor;
    assign o_error  = w_error;

endmodule

`default_nettype wire

// ===== hdl/cursor_sequence_store_core.sv =====
// Cursor sequence store: ordered store of up to CAPACITY values with a cursor.
// Input channel: i_in_valid / o_in_ready carry a command and a value. Commands
// are start, advance, insert before, attach after and remove current.
// Output channel: o_out_valid / i_out_ready carry one status per command:
// item count, has-current flag, current value, cursor and error code.
// Order: a command updates the cell chain and cursor at its transfer and sets
// a pending flag; the status is then registered into the output register,
// from which o_out_valid and the status are presented to the receiver.
// Throughput: one command per cycle while the receiver takes each status.
// Every cell decides shift, load or hold from a broadcast of the controller, so
// a whole insert or remove completes at its transfer, before the status read.
// Reset (synchronous, active low) empties the store and clears the cursor;
// cell contents are not cleared, only entries below the count are read.
// When the receiver stalls, one finished status waits in the output register
// and one more command may complete behind it; input then holds off until
// the output register is taken.
// Depends on csc_pkg, csc_ctrl, csc_cell and the macro header.
`default_nettype none
`include "cursor_sequence_store_core_macros.svh"

module cursor_sequence_store_core #(
    parameter int unsigned CAPACITY    = csc_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_WIDTH = csc_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned CNT_W       = $clog2(CAPACITY + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [2:0]             i_command,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [CNT_W-1:0]            o_item_total,
    output logic                        o_has_current,
    output logic [VALUE_WIDTH-1:0]      o_current_value,
    output logic [CNT_W-1:0]            o_cursor,
    output logic [1:0]                  o_error
);

    localparam int unsigned IDX_W = $clog2(CAPACITY);

    logic                   w_in_fire;
    logic                   w_load;
    csc_pkg::t_cell_ctl     w_ctl;
    logic [CNT_W-1:0]       w_pos;
    logic [CNT_W-1:0]       w_count;
    logic [CNT_W-1:0]       w_cursor;
    logic [1:0]             w_error;
    logic                   w_has;
    logic [VALUE_WIDTH-1:0] w_cell_q [CAPACITY];
    logic                   w_has_out;
    logic                   w_full_err;

    logic                   r_pend;
    logic [1:0]             r_pend_err;
    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_item_total;
    logic                   r_has_current;
    logic [VALUE_WIDTH-1:0] r_current_value;
    logic [CNT_W-1:0]       r_cursor_out;
    logic [1:0]             r_error;

    // Handshake
    assign w_load     = r_pend & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_pend | w_load;
    assign w_in_fire  = i_in_valid & o_in_ready;

    csc_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_in_fire),
        .i_command (i_command),
        .o_ctl     (w_ctl),
        .o_pos     (w_pos),
        .o_count   (w_count),
        .o_cursor  (w_cursor),
        .o_error   (w_error)
    );

    // Chain of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_q[g];
        end else begin : g_mid_r
            assign w_right = w_cell_q[g+1];
        end

        csc_cell #(
            .INDEX       (g),
            .POS_W       (CNT_W),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_cell_q[g])
        );
    end

    assign w_has = (w_cursor < w_count);

    // Pending status between update and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_in_fire) begin
            r_pend <= 1'b1;
        end else if (w_load) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_pend_err <= w_error;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item_total    <= w_count;
            r_has_current   <= w_has;
            r_current_value <= w_has ? w_cell_q[w_cursor[IDX_W-1:0]] : '0;
            r_cursor_out    <= w_cursor;
            r_error         <= r_pend_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_item_total    = r_item_total;
    assign o_has_current   = r_has_current;
    assign o_current_value = r_current_value;
    assign o_cursor        = r_cursor_out;
    assign o_error         = r_error;

    // Terms for the checks
    assign w_has_out  = (o_cursor < o_item_total);
    assign w_full_err = o_out_valid && (o_error == csc_pkg::ERR_FULL);

    // Checks
    `CSC_ASSERT_IMPL(a_cursor_in_range, i_clk, i_rst_n, 1'b1, w_cursor <= w_count)
    `CSC_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1, w_count <= CNT_W'(CAPACITY))
    `CSC_ASSERT_IMPL(a_has_current, i_clk, i_rst_n, o_out_valid, o_has_current == w_has_out)
    `CSC_ASSERT_IMPL(a_full_err, i_clk, i_rst_n, w_full_err, o_item_total == CNT_W'(CAPACITY))
    `CSC_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_load, o_out_valid)

endmodule

`default_nettype wire
